// ----- sv/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES     = 262144;
   localparam int KERNEL_PAGES  = 4096;
   localparam int MAP_WORD_BITS = 32;
   localparam int PAGE_SHIFT    = 12;
   localparam int MAP_WORDS     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int KERNEL_HI     = (KERNEL_PAGES > MAX_PAGES) ? MAX_PAGES : KERNEL_PAGES;

   localparam int WORD_W = $clog2(MAP_WORDS);
   localparam int BIT_W  = $clog2(MAP_WORD_BITS);
   localparam int PAGE_W = 19;
   localparam int NPG_W  = 20;
   localparam int RUN_W  = 20;
   localparam int POP_W  = BIT_W + 1;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;
   localparam logic [1:0] OP_COUNT   = 2'd3;

   localparam logic [1:0] REGION_KERNEL = 2'd0;
   localparam logic [1:0] REGION_USER   = 2'd1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_BADREGN = 2'd2;
   localparam logic [1:0] STATUS_UNUSED  = 2'd3;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SCAN,
      MODE_MARK,
      MODE_COUNT
   } mode_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_EXEC,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      mode_type          mode;
      logic              set;
      logic [1:0]        status;
      logic [PAGE_W-1:0] lo;
      logic [PAGE_W-1:0] hi;
      logic [NPG_W-1:0]  npages;
   } cmd_type;

endpackage

// ----- sv/bpa_front.sv -----
// ----------------------------------------------------------------------------
// bpa_front
// Decodes a request into a page-range command for the back end.
// ----------------------------------------------------------------------------
module bpa_front import bpa_pkg::*; (
   input  logic [1:0]        req_operation,
   input  logic [1:0]        req_region,
   input  logic [30:0]       req_size_bytes,
   input  logic [29:0]       req_address,
   input  logic [PAGE_W-1:0] eff_total,
   output cmd_type           cmd
);

   logic [30:0]       size_m1;
   logic [NPG_W-1:0]  npages;
   logic [17:0]       first;
   logic [NPG_W:0]    first_end;
   logic [PAGE_W-1:0] mark_end;

   always_comb begin
      size_m1   = (req_size_bytes == 31'd0) ? 31'd0 : req_size_bytes - 31'd1;
      npages    = NPG_W'(size_m1 >> PAGE_SHIFT) + NPG_W'(1);
      first     = req_address[29:PAGE_SHIFT];
      first_end = (NPG_W+1)'(first) + (NPG_W+1)'(npages);
      mark_end  = (first_end > (NPG_W+1)'(eff_total)) ? eff_total : first_end[PAGE_W-1:0];

      cmd        = '0;
      cmd.mode   = MODE_NONE;
      cmd.npages = npages;
      unique case (req_operation)
         OP_ALLOC: begin
            if (req_region == REGION_KERNEL) begin
               cmd.mode   = MODE_SCAN;
               cmd.status = STATUS_NOFIT;
               cmd.lo     = '0;
               cmd.hi     = PAGE_W'(KERNEL_HI);
            end else if (req_region == REGION_USER) begin
               cmd.status = STATUS_NOFIT;
               cmd.lo     = PAGE_W'(KERNEL_PAGES);
               cmd.hi     = eff_total;
               if (PAGE_W'(KERNEL_PAGES) < eff_total) begin
                  cmd.mode = MODE_SCAN;
               end
            end else begin
               cmd.status = STATUS_BADREGN;
            end
         end
         OP_FREE, OP_RESERVE: begin
            cmd.status = STATUS_OK;
            cmd.set    = (req_operation == OP_RESERVE);
            cmd.lo     = PAGE_W'(first);
            cmd.hi     = mark_end;
            if (PAGE_W'(first) < eff_total) begin
               cmd.mode = MODE_MARK;
            end
         end
         OP_COUNT: begin
            cmd.status = STATUS_OK;
            cmd.lo     = '0;
            cmd.hi     = eff_total;
            if (eff_total != '0) begin
               cmd.mode = MODE_COUNT;
            end
         end
         default: cmd.mode = MODE_NONE;
      endcase
   end

endmodule

// ----- sv/bpa_queue.sv -----
// ----------------------------------------------------------------------------
// bpa_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bpa_queue import bpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/bpa_back.sv -----
// ----------------------------------------------------------------------------
// bpa_back
// Holds the page map memory and walks it one map word at a time to scan,
// mark or count pages, then presents the response.
// ----------------------------------------------------------------------------
module bpa_back import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [29:0] rsp_address_res,
   output logic [30:0] rsp_free_bytes
);

   logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] rdata_ff;

   back_state_type    state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic              set_ff, set_in;
   logic [1:0]        stat_ff, stat_in;
   logic [PAGE_W-1:0] lo_ff, lo_in;
   logic [PAGE_W-1:0] hi_ff, hi_in;
   logic [NPG_W-1:0]  npg_ff, npg_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [PAGE_W-1:0] cnt_ff, cnt_in;
   logic [17:0]       page_ff, page_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [29:0]       rsp_addr_ff;
   logic [30:0]       rsp_free_ff;
   logic              rsp_load;

   logic                     we;
   logic [WORD_W-1:0]        waddr;
   logic [MAP_WORD_BITS-1:0] wdata;

   logic [PAGE_W-1:0]        base;
   logic [PAGE_W-1:0]        lane_page;
   logic [MAP_WORD_BITS-1:0] in_range;
   logic [MAP_WORD_BITS-1:0] used;
   logic                     have_used;
   logic [BIT_W-1:0]         last_used;
   logic [POP_W-1:0]         tail;
   logic [RUN_W-1:0]         run_lane;
   logic                     hit;
   logic [BIT_W-1:0]         hit_bit;
   logic [POP_W-1:0]         free_pop;
   logic [RUN_W:0]           at_full;
   logic [PAGE_W-1:0]        last_page;
   logic                     last_word;

   always_comb begin
      base      = PAGE_W'({word_ff, BIT_W'(0)});
      have_used = 1'b0;
      last_used = '0;
      run_lane  = '0;
      hit       = 1'b0;
      hit_bit   = '0;
      free_pop  = '0;
      tail      = '0;
      lane_page = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         lane_page   = base + PAGE_W'(j);
         in_range[j] = (lane_page >= lo_ff) && (lane_page < hi_ff);
         used[j]     = rdata_ff[j] || !in_range[j];
         if (used[j]) begin
            have_used = 1'b1;
            last_used = BIT_W'(j);
         end
         tail     = have_used ? POP_W'(BIT_W'(j) - last_used) : POP_W'(j + 1);
         run_lane = have_used ? RUN_W'(tail) : run_ff + RUN_W'(tail);
         if (!hit && !used[j] && (run_lane >= RUN_W'(npg_ff))) begin
            hit     = 1'b1;
            hit_bit = BIT_W'(j);
         end
         free_pop = free_pop + POP_W'(!used[j]);
      end
      at_full   = (RUN_W+1)'(base) + (RUN_W+1)'(hit_bit) + (RUN_W+1)'(1)
                  - (RUN_W+1)'(npg_ff);
      last_page = hi_ff - PAGE_W'(1);
      last_word = (word_ff == last_page[WORD_W+BIT_W-1:BIT_W]);
   end

   assign rsp_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      set_in       = set_ff;
      stat_in      = stat_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      npg_in       = npg_ff;
      word_in      = word_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      page_in      = page_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_pop      = 1'b0;
      we           = 1'b0;
      waddr        = word_ff;
      wdata        = '0;
      unique case (state_ff)
         BK_CLEAR: begin
            we      = 1'b1;
            word_in = word_ff + WORD_W'(1);
            if (word_ff == WORD_W'(MAP_WORDS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               mode_in = cmd.mode;
               set_in  = cmd.set;
               stat_in = cmd.status;
               lo_in   = cmd.lo;
               hi_in   = cmd.hi;
               npg_in  = cmd.npages;
               word_in = cmd.lo[WORD_W+BIT_W-1:BIT_W];
               run_in  = '0;
               cnt_in  = '0;
               page_in = '0;
               state_in = (cmd.mode == MODE_NONE) ? BK_RESP : BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            state_in = BK_READ;
            unique case (mode_ff)
               MODE_SCAN: begin
                  if (hit) begin
                     mode_in = MODE_MARK;
                     set_in  = 1'b1;
                     stat_in = STATUS_OK;
                     lo_in   = at_full[PAGE_W-1:0];
                     hi_in   = base + PAGE_W'(hit_bit) + PAGE_W'(1);
                     page_in = at_full[17:0];
                     word_in = at_full[WORD_W+BIT_W-1:BIT_W];
                  end else if (last_word) begin
                     state_in = BK_RESP;
                  end else begin
                     run_in  = run_lane;
                     word_in = word_ff + WORD_W'(1);
                  end
               end
               MODE_MARK: begin
                  we    = 1'b1;
                  wdata = set_ff ? (rdata_ff | in_range) : (rdata_ff & ~in_range);
                  word_in = word_ff + WORD_W'(1);
                  if (last_word) begin
                     state_in = BK_RESP;
                  end
               end
               MODE_COUNT: begin
                  cnt_in  = cnt_ff + PAGE_W'(free_pop);
                  word_in = word_ff + WORD_W'(1);
                  if (last_word) begin
                     state_in = BK_RESP;
                  end
               end
               default: state_in = BK_RESP;
            endcase
         end
         BK_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         word_ff      <= '0;
         mode_ff      <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff  <= set_in;
      stat_ff <= stat_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      npg_ff  <= npg_in;
      run_ff  <= run_in;
      cnt_ff  <= cnt_in;
      page_ff <= page_in;
      if (state_ff == BK_RESP && rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_addr_ff   <= (stat_ff == STATUS_OK && mode_ff == MODE_MARK && set_ff
                           && page_ff != '0) ? {page_ff, 12'd0} : 30'd0;
         rsp_free_ff   <= (mode_ff == MODE_COUNT) ? {cnt_ff, 12'd0} : 31'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[word_ff];
   end

   assign clearing        = (state_ff == BK_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_address_res = rsp_addr_ff;
   assign rsp_free_bytes  = rsp_free_ff;

endmodule

// ----- sv/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a one-bit-per-page use map.
// ----------------------------------------------------------------------------
// After reset the map memory is cleared one word a cycle, all 8192 words, and no
// request is taken until that is done. Each request then reads each map word
// that it visits and then acts on it: allocate walks the region words up to
// the hit and then the words of the new run, free and reserve walk the words
// of their range, and count walks every word below the total. The one map
// memory port sets the pace; a queue of two decoded requests sits ahead.
module bitmap_page_allocator import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_region,
   input  logic [30:0] req_size_bytes,
   input  logic [29:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [29:0] rsp_address_res,
   output logic [30:0] rsp_free_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [18:0] csr_total_pages
);

   logic [18:0]       total_ff;
   logic [PAGE_W-1:0] eff_total;
   cmd_type           dec_cmd;
   cmd_type           head_cmd;
   logic              q_full;
   logic              q_ne;
   logic              q_pop;
   logic              clearing;

   assign csr_ready = 1'b1;
   assign eff_total = (total_ff > 19'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : total_ff;
   assign req_ready = !q_full && !clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 19'(MAX_PAGES);
      end else if (csr_valid && csr_ready) begin
         total_ff <= csr_total_pages;
      end
   end

   bpa_front u_front (
      .req_operation (req_operation),
      .req_region    (req_region),
      .req_size_bytes(req_size_bytes),
      .req_address   (req_address),
      .eff_total     (eff_total),
      .cmd           (dec_cmd)
   );

   bpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid && req_ready),
      .push_cmd (dec_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_ne),
      .head     (head_cmd)
   );

   bpa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_ne),
      .cmd            (head_cmd),
      .cmd_pop        (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_address_res(rsp_address_res),
      .rsp_free_bytes (rsp_free_bytes)
   );

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready) else $error("request taken during map clear");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_UNUSED) else $error("bad status code");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_address_res == '0)
      else $error("address on failed request");

   a_free_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_free_bytes != '0 |-> rsp_status == STATUS_OK &&
      rsp_address_res == '0) else $error("free count on wrong response");

endmodule
